>>> hdl/dstwr_pkg.sv
// ----------------------------------------------------------------------------
// dstwr_pkg
// Shared widths, opcodes and stream packing for the DS-TWR time of flight.
// ----------------------------------------------------------------------------
`default_nettype none

package dstwr_pkg;

  // Width of each stamp / peer field on the stream
  localparam int FIELD_BITS = 40;
  // Default stamp width (differences wrap here)
  localparam int STAMP_BITS_DEF = 40;
  // Width of the checked products and sums
  localparam int PROD_BITS = 64;
  // Exact sum of four stamp-sized terms, two bits of headroom
  localparam int SUM_BITS = PROD_BITS + 2;

  localparam int IN_DATA_BITS  = 4 * FIELD_BITS;
  localparam int OUT_DATA_BITS = FIELD_BITS;
  localparam int OUT_USER_BITS = 2;

  // Output tuser bit positions
  localparam int TUSER_TOF_VALID = 0;
  localparam int TUSER_OVF_ERROR = 1;

  // Input tuser opcodes
  localparam logic OP_REPLY = 1'b0;
  localparam logic OP_PONG  = 1'b1;

endpackage

`default_nettype wire

>>> hdl/ds_twr_time_of_flight.sv
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight
// Reply item: the result stage is entered on acceptance; one item in flight
// at a time, so the next transfer waits until the result is handed over.
// Pong item: serial multiply (both products side by side), a step to see them
// finish, a check step, serial divide, a step to see it finish, a result step.
// Pong with a fault skips the divide.
// A full output register holds the result stage, and the input with it.
// Synchronous reset clears control and the stored own reply delay.
// ----------------------------------------------------------------------------
`default_nettype none

module ds_twr_time_of_flight #(
  parameter int STAMP_BITS = dstwr_pkg::STAMP_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // rx_time, tx_stamp, peer_round, peer_reply (from bit 0 up)
  input  wire  [dstwr_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // opcode
  input  wire                                 s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // tof
  output logic [dstwr_pkg::OUT_DATA_BITS-1:0] m_tdata,
  // tof_valid, overflow_error (from bit 0 up)
  output logic [dstwr_pkg::OUT_USER_BITS-1:0] m_tuser
);

  localparam int FW = dstwr_pkg::FIELD_BITS;
  localparam int PW = dstwr_pkg::PROD_BITS;
  localparam int SW = dstwr_pkg::SUM_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_RESULT
  } state_t;

  state_t state;

  logic [FW-1:0] rx_time;
  logic [FW-1:0] tx_stamp;
  logic [FW-1:0] peer_round;
  logic [FW-1:0] peer_reply;
  logic          accept;

  logic [PW-1:0]         round_wide;
  logic [PW-1:0]         reply_wide;
  logic [STAMP_BITS-1:0] own_round_in;
  logic [STAMP_BITS-1:0] own_delay_in;

  logic [STAMP_BITS-1:0] own_reply_delay;
  logic [STAMP_BITS-1:0] own_round;
  logic [SW-1:0]         sum;
  logic                  add_pend;
  logic                  add_first;

  logic                  mul_start;
  logic                  mul_r_done;
  logic                  mul_d_done;
  logic [PW-1:0]         prod_r;
  logic [PW-1:0]         prod_d;
  logic                  ovf_r;
  logic                  ovf_d;

  logic                  fault;
  logic [PW-1:0]         diff;
  logic                  div_start;
  logic                  div_done;
  logic [FW-1:0]         quo;

  logic [FW-1:0]         res_tof;
  logic                  res_valid;
  logic                  res_err;

  assign rx_time    = s_tdata[FW-1:0];
  assign tx_stamp   = s_tdata[2*FW-1:FW];
  assign peer_round = s_tdata[3*FW-1:2*FW];
  assign peer_reply = s_tdata[4*FW-1:3*FW];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;

  // Stamp differences wrap at STAMP_BITS
  always_comb begin
    round_wide   = PW'(rx_time) - PW'(tx_stamp);
    reply_wide   = PW'(tx_stamp) - PW'(rx_time);
    own_round_in = round_wide[STAMP_BITS-1:0];
    own_delay_in = reply_wide[STAMP_BITS-1:0];
  end

  assign mul_start = accept & (s_tuser == dstwr_pkg::OP_PONG);

  dstwr_mul #(
    .A_BITS (STAMP_BITS),
    .B_BITS (FW)
  ) u_mul_round (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (own_round_in),
    .b     (peer_round),
    .done  (mul_r_done),
    .prod  (prod_r),
    .ovf   (ovf_r)
  );

  dstwr_mul #(
    .A_BITS (STAMP_BITS),
    .B_BITS (FW)
  ) u_mul_reply (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (own_reply_delay),
    .b     (peer_reply),
    .done  (mul_d_done),
    .prod  (prod_d),
    .ovf   (ovf_d)
  );

  // Any partial sum past 64 bits shows up in the exact sum's top bits
  always_comb begin
    fault = ovf_r | ovf_d | (sum[SW-1:PW] != '0) | (sum[PW-1:0] == '0);
    diff  = (prod_r >= prod_d) ? (prod_r - prod_d) : (prod_d - prod_r);
  end

  assign div_start = (state == ST_CHECK) & ~fault;

  dstwr_div #(
    .Q_BITS (FW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (sum[PW-1:0]),
    .done     (div_done),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      own_reply_delay <= '0;
      add_pend        <= 1'b0;
      add_first       <= 1'b0;
    end else begin
      // the result stage drives tvalid itself when it hands over
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == dstwr_pkg::OP_REPLY) begin
              own_reply_delay <= own_delay_in;
              res_tof         <= '0;
              res_valid       <= 1'b0;
              res_err         <= 1'b0;
              state           <= ST_RESULT;
            end else begin
              own_round <= own_round_in;
              sum       <= SW'(peer_round) + SW'(peer_reply);
              add_pend  <= 1'b1;
              add_first <= 1'b1;
              state     <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // fold in own round, then own reply delay, while the products run
          if (add_pend) begin
            sum <= sum + (add_first ? SW'(own_round) : SW'(own_reply_delay));
            if (add_first) begin
              add_first <= 1'b0;
            end else begin
              add_pend <= 1'b0;
            end
          end
          if (mul_r_done) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (fault) begin
            res_tof   <= '0;
            res_valid <= 1'b0;
            res_err   <= 1'b1;
            state     <= ST_RESULT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_tof   <= quo;
            res_valid <= 1'b1;
            res_err   <= 1'b0;
            state     <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          // hand over once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid                          <= 1'b1;
            m_tdata                           <= res_tof;
            m_tuser[dstwr_pkg::TUSER_TOF_VALID] <= res_valid;
            m_tuser[dstwr_pkg::TUSER_OVF_ERROR] <= res_err;
            state                             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_valid_err_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[dstwr_pkg::TUSER_TOF_VALID] &&
                   m_tuser[dstwr_pkg::TUSER_OVF_ERROR]))
    else $error("tof_valid and overflow_error both set");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mul_r_done == mul_d_done)
    else $error("multipliers out of step");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  a_sum_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && mul_r_done) |-> !add_pend)
    else $error("sum still pending at end of multiply");

  a_reply_result: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == dstwr_pkg::OP_REPLY) |=> state == ST_RESULT)
    else $error("reply transfer did not go to result stage");

endmodule

`default_nettype wire

>>> hdl/dstwr_mul.sv
// ----------------------------------------------------------------------------
// dstwr_mul
// Bit-serial multiplier, MSB first over operand b, with a sticky flag for a
// product that does not fit in PROD_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module dstwr_mul #(
  parameter int A_BITS = dstwr_pkg::STAMP_BITS_DEF,
  parameter int B_BITS = dstwr_pkg::FIELD_BITS
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire  [A_BITS-1:0]              a,
  input  wire  [B_BITS-1:0]              b,
  output logic                           done,
  output logic [dstwr_pkg::PROD_BITS-1:0] prod,
  output logic                           ovf
);

  localparam int PW    = dstwr_pkg::PROD_BITS;
  localparam int ACC_W = PW + 1;
  localparam int CNT_W = $clog2(B_BITS + 1);

  logic [A_BITS-1:0] a_hold;
  logic [B_BITS-1:0] b_shift;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [ACC_W-1:0]  acc_next;

  // Double the accumulator, then add a when the current multiplier bit is set
  always_comb begin
    acc_next = ACC_W'({prod[PW-2:0], 1'b0}) +
               (b_shift[B_BITS-1] ? ACC_W'(a_hold) : ACC_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(B_BITS);
        a_hold  <= a;
        b_shift <= b;
        prod    <= '0;
        ovf     <= 1'b0;
      end else if (busy) begin
        prod    <= acc_next[PW-1:0];
        ovf     <= ovf | prod[PW-1] | acc_next[PW];
        b_shift <= {b_shift[B_BITS-2:0], 1'b0};
        cnt     <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/dstwr_div.sv
// ----------------------------------------------------------------------------
// dstwr_div
// Restoring divider, one quotient bit per cycle; keeps the low Q_BITS of the
// quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dstwr_div #(
  parameter int Q_BITS = dstwr_pkg::FIELD_BITS
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [dstwr_pkg::PROD_BITS-1:0] dividend,
  input  wire  [dstwr_pkg::PROD_BITS-1:0] divisor,
  output logic                            done,
  output logic [Q_BITS-1:0]               quo
);

  localparam int PW    = dstwr_pkg::PROD_BITS;
  localparam int CNT_W = $clog2(PW + 1);

  logic [PW-1:0]    rem;
  logic [PW-1:0]    dvd;
  logic [PW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [PW:0]      shifted;
  logic [PW:0]      trial;
  logic             q_bit;

  always_comb begin
    shifted = {rem, dvd[PW-1]};
    trial   = shifted - {1'b0, dsr};
    q_bit   = ~trial[PW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PW);
        rem  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        quo  <= '0;
      end else if (busy) begin
        // restore on borrow; remainder stays below the divisor
        rem <= q_bit ? trial[PW-1:0] : shifted[PW-1:0];
        dvd <= {dvd[PW-2:0], 1'b0};
        quo <= {quo[Q_BITS-2:0], q_bit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the DS-TWR time of flight unit. Directed reply and
// pong transfers cover stamp wrap, zero divisor, product overflow at its
// boundary and mirrored differences. Random ranging exchanges and noise
// follow, with random gaps on both sides. Every result is checked against
// a predictor with 128-bit products kept in a small scoreboard.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [dstwr_pkg::FIELD_BITS-1:0] tof;
  logic                             tof_valid;
  logic                             ovf_error;
} tof_result_t;

class tof_scoreboard;
  localparam int          FB         = dstwr_pkg::FIELD_BITS;
  localparam logic [63:0] STAMP_MASK = (64'd1 << dstwr_pkg::STAMP_BITS_DEF) - 64'd1;

  logic [63:0] own_reply;
  tof_result_t expected_q[$];
  int          errors;
  int          replies;
  int          pongs;
  int          faults;
  int          mirrored;

  function new();
    own_reply = '0;
    errors    = 0;
    replies   = 0;
    pongs     = 0;
    faults    = 0;
    mirrored  = 0;
  endfunction

  // Predict the result of one accepted transfer.
  function void note_input(logic op, logic [FB-1:0] rx, logic [FB-1:0] tx,
                           logic [FB-1:0] peer_round, logic [FB-1:0] peer_reply);
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] prod_round;
    logic [127:0] prod_reply;
    logic [127:0] divisor;
    logic [63:0]  own_round;
    logic [63:0]  diff;
    tof_result_t  r;
    r = '0;
    if (op == dstwr_pkg::OP_REPLY) begin
      own_reply = ({24'b0, tx} - {24'b0, rx}) & STAMP_MASK;
      replies++;
    end else begin
      pongs++;
      own_round = ({24'b0, rx} - {24'b0, tx}) & STAMP_MASK;
      a = 128'(peer_round);
      b = 128'(own_round);
      prod_round = a * b;
      a = 128'(peer_reply);
      b = 128'(own_reply);
      prod_reply = a * b;
      divisor = 128'(peer_round) + 128'(peer_reply) + 128'(own_round) + 128'(own_reply);
      if (prod_round[127:64] != 0 || prod_reply[127:64] != 0 || divisor[127:64] != 0 ||
          divisor == 0) begin
        r.ovf_error = 1'b1;
        faults++;
      end else begin
        if (prod_round[63:0] >= prod_reply[63:0]) begin
          diff = prod_round[63:0] - prod_reply[63:0];
        end else begin
          diff = prod_reply[63:0] - prod_round[63:0];
          mirrored++;
        end
        r.tof       = FB'(diff / divisor[63:0]);
        r.tof_valid = 1'b1;
      end
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [FB-1:0] tof,
                             logic [dstwr_pkg::OUT_USER_BITS-1:0] user);
    tof_result_t exp_r;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: tof=%h tuser=%b", $time, tof, user);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (tof !== exp_r.tof) begin
      $display("%0t: tof mismatch: expected %h, actual %h", $time, exp_r.tof, tof);
      errors++;
    end
    if (user[dstwr_pkg::TUSER_TOF_VALID] !== exp_r.tof_valid) begin
      $display("%0t: tof_valid mismatch: expected %b, actual %b", $time, exp_r.tof_valid,
               user[dstwr_pkg::TUSER_TOF_VALID]);
      errors++;
    end
    if (user[dstwr_pkg::TUSER_OVF_ERROR] !== exp_r.ovf_error) begin
      $display("%0t: overflow_error mismatch: expected %b, actual %b", $time,
               exp_r.ovf_error, user[dstwr_pkg::TUSER_OVF_ERROR]);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int          FB    = dstwr_pkg::FIELD_BITS;
  localparam logic [FB-1:0] MAX40 = '1;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 s_tvalid = 1'b0;
  logic                                 s_tready;
  logic [dstwr_pkg::IN_DATA_BITS-1:0]   s_tdata = '0;
  logic                                 s_tuser = dstwr_pkg::OP_REPLY;
  logic                                 m_tvalid;
  logic                                 m_tready = 1'b0;
  logic [dstwr_pkg::OUT_DATA_BITS-1:0]  m_tdata;
  logic [dstwr_pkg::OUT_USER_BITS-1:0]  m_tuser;

  tof_scoreboard sb;
  bit            calm_tx = 1'b0;
  bit            calm_rx = 1'b0;
  int            sent = 0;

  ds_twr_time_of_flight DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [FB-1:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (w <= 0) return '0;
    return FB'(v & ((64'd1 << w) - 64'd1));
  endfunction

  task automatic send_item(logic op, logic [FB-1:0] rx, logic [FB-1:0] tx,
                           logic [FB-1:0] peer_round, logic [FB-1:0] peer_reply);
    int gap;
    gap = calm_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {peer_reply, peer_round, tx, rx};
    do @(posedge clk); while (s_tready !== 1'b1);
    sb.note_input(op, rx, tx, peer_round, peer_reply);
    sent++;
  endtask

  // Drop tvalid and hold off until every pending result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // One well-formed ranging exchange: reply then pong.
  task automatic send_exchange();
    logic [FB-1:0] flight;
    logic [FB-1:0] own_delay;
    logic [FB-1:0] peer_delay;
    logic [FB-1:0] stamp;
    logic [FB-1:0] skew;
    flight     = FB'($urandom_range(0, 4000));
    own_delay  = rand_bits($urandom_range(0, 30));
    peer_delay = rand_bits($urandom_range(0, 30));
    stamp      = rand_bits(FB);
    send_item(dstwr_pkg::OP_REPLY, stamp, stamp + own_delay,
              rand_bits($urandom_range(0, 40)), rand_bits($urandom_range(0, 40)));
    stamp = rand_bits(FB);
    skew  = FB'($urandom_range(0, 3));
    send_item(dstwr_pkg::OP_PONG, stamp + peer_delay + (flight << 1), stamp,
              own_delay + (flight << 1) + skew, peer_delay);
  endtask

  task automatic send_noise();
    send_item(logic'($urandom_range(0, 1)), rand_bits($urandom_range(0, 40)),
              rand_bits($urandom_range(0, 40)), rand_bits($urandom_range(0, 40)),
              rand_bits($urandom_range(0, 40)));
  endtask

  // Result side: random stalls between transfers.
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = calm_rx ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero divisor straight out of reset
    send_item(dstwr_pkg::OP_PONG, '0, '0, '0, '0);
    send_item(dstwr_pkg::OP_REPLY, '0, '0, MAX40, MAX40);
    send_item(dstwr_pkg::OP_PONG, 40'd5, 40'd5, '0, '0);
    // Stamp wrap on both differences
    send_item(dstwr_pkg::OP_REPLY, MAX40, 40'd10, '0, '0);
    send_item(dstwr_pkg::OP_PONG, 40'd2, MAX40, 40'd100, 40'd7);
    // Reply side larger: mirrored difference
    send_item(dstwr_pkg::OP_PONG, 40'd1001, 40'd1000, 40'd1, 40'd1000);
    // Product overflow, and the boundary just below it
    send_item(dstwr_pkg::OP_PONG, MAX40, '0, MAX40, '0);
    send_item(dstwr_pkg::OP_PONG, 40'h00_FFFF_FFFF, '0, 40'h01_0000_0000, '0);
    send_item(dstwr_pkg::OP_PONG, 40'h01_0000_0000, '0, 40'h01_0000_0000, '0);
    send_item(dstwr_pkg::OP_REPLY, '0, MAX40, '0, '0);
    send_item(dstwr_pkg::OP_PONG, 40'd50, 40'd20, '0, MAX40);
    send_item(dstwr_pkg::OP_PONG, 40'd50, 40'd20, 40'd3, 40'd1);
    send_item(dstwr_pkg::OP_PONG, MAX40, MAX40, MAX40, MAX40);
    send_item(dstwr_pkg::OP_REPLY, 40'h12_3456_7890, 40'h12_3457_0000, MAX40, '0);
    send_item(dstwr_pkg::OP_PONG, 40'hAA_0000_9000, 40'hAA_0000_1000, 40'h7F00, 40'h3000);
    send_item(dstwr_pkg::OP_PONG, 40'h55_5555_5555, 40'h2A_AAAA_AAAA, '0, '0);
    send_exchange();
    drain();

    // Random: phases of exchanges and noise, varying the idle pattern
    while (sent < 1850) begin
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      repeat (100) begin
        if ($urandom_range(0, 9) < 7) begin
          send_exchange();
        end else begin
          send_noise();
        end
      end
      if ($urandom_range(0, 1) == 0) drain();
    end
    calm_rx = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    $display("Ran %0d transfers: %0d reply events, %0d pong events.", sent, sb.replies,
             sb.pongs);
    $display("Pongs with arithmetic fault: %0d; mirrored differences: %0d.", sb.faults,
             sb.mirrored);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
